// ----- sv/qrs_pkg.sv -----
// Shared constants, codes and types of the quadratic root solver.
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;

  localparam int COEF_W      = 32;
  localparam int FRAC_BITS   = 16;
  localparam int MAG_W       = COEF_W;
  localparam int PROD_W      = 2 * MAG_W;
  localparam int DISC_W      = PROD_W + 2;
  localparam int SQ_RAD_W    = PROD_W + 2 * FRAC_BITS;
  localparam int SQ_ROOT_W   = SQ_RAD_W / 2;
  localparam int SQ_REM_W    = SQ_ROOT_W + 4;
  localparam int SUM_W       = MAG_W + 1;
  localparam int DIV_DEN_W   = MAG_W + 1;
  localparam int DIV_NUM_W   = SUM_W + FRAC_BITS;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 72;
  localparam int COUNT_W     = 2;

  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = 2;
  localparam int FIFO_CNT_W  = 3;

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_LIN  = 3'd1;
  localparam logic [2:0] KIND_GEN  = 3'd2;
  localparam logic [2:0] KIND_SYM  = 3'd3;
  localparam logic [2:0] KIND_DBL  = 3'd4;

  localparam logic [COUNT_W-1:0] COUNT_NONE = 2'd0;
  localparam logic [COUNT_W-1:0] COUNT_ONE  = 2'd1;
  localparam logic [COUNT_W-1:0] COUNT_TWO  = 2'd2;

  localparam logic [DIV_NUM_W-1:0] SAT_NEG_MAG = DIV_NUM_W'(1) << (COEF_W - 1);
  localparam logic [DIV_NUM_W-1:0] SAT_POS_MAG = SAT_NEG_MAG - DIV_NUM_W'(1);
  localparam logic [COEF_W-1:0]    ROOT_MIN    = {1'b1, {(COEF_W - 1){1'b0}}};
  localparam logic [COEF_W-1:0]    ROOT_MAX    = {1'b0, {(COEF_W - 1){1'b1}}};

  // Classified coefficients: case, signs and magnitudes of c2, c1, c0.
  typedef struct packed {
    logic [2:0]       kind;
    logic             sa;
    logic             sb;
    logic             sc;
    logic [MAG_W-1:0] ma;
    logic [MAG_W-1:0] mb;
    logic [MAG_W-1:0] mc;
  } item_t;

  typedef struct packed {
    item_t                item;
    logic [SQ_RAD_W-1:0]  radicand;
  } qitem_t;

endpackage
`default_nettype wire

// ----- sv/qrs_front.sv -----
// Front end: takes coefficient transactions, forms the discriminant and classifies the case.
`timescale 1ns / 1ps
`default_nettype none
module qrs_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [qrs_pkg::IN_TDATA_W-1:0] s_tdata,
  output logic                                wr_valid,
  input  wire logic                           wr_ready,
  output qrs_pkg::qitem_t                     wr_data
);
  import qrs_pkg::*;

  logic             en;
  logic             v1, v2;
  logic             sa1, sb1, sc1;
  logic [MAG_W-1:0] ma1, mb1, mc1;
  logic             sa2, sb2, sc2;
  logic [MAG_W-1:0] ma2, mb2, mc2;
  logic [PROD_W-1:0] p2, pq2;

  logic [DISC_W-1:0]   p_ext, q4, disc_sum, disc_dif;
  logic                opposite;
  logic [2:0]          kind;
  logic [SQ_RAD_W-1:0] radicand;

  function automatic logic [MAG_W-1:0] mag_of(input logic [COEF_W-1:0] raw);
    return raw[COEF_W-1] ? (~raw + COEF_W'(1)) : raw;
  endfunction

  assign en       = !v2 || wr_ready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc1 <= s_tdata[COEF_W-1];
      sb1 <= s_tdata[2*COEF_W-1];
      sa1 <= s_tdata[3*COEF_W-1];
      mc1 <= mag_of(s_tdata[COEF_W-1:0]);
      mb1 <= mag_of(s_tdata[2*COEF_W-1:COEF_W]);
      ma1 <= mag_of(s_tdata[3*COEF_W-1:2*COEF_W]);
      sa2 <= sa1;
      sb2 <= sb1;
      sc2 <= sc1;
      ma2 <= ma1;
      mb2 <= mb1;
      mc2 <= mc1;
      p2  <= mb1 * mb1;
      pq2 <= ma1 * mc1;
    end
  end

  // With c2 and c0 of opposite sign the discriminant is b^2 + 4|ac| and always positive.
  always_comb begin
    p_ext    = {2'b00, p2};
    q4       = {pq2, 2'b00};
    disc_sum = p_ext + q4;
    disc_dif = p_ext - q4;
    opposite = (mc2 != '0) && (sa2 != sc2);
    radicand = '0;
    kind     = KIND_NONE;
    if (ma2 == '0) begin
      kind = (mb2 != '0) ? KIND_LIN : KIND_NONE;
    end else if (opposite || (p_ext > q4)) begin
      if (mb2 == '0) begin
        kind     = KIND_SYM;
        radicand = {pq2, {(2 * FRAC_BITS){1'b0}}};
      end else begin
        kind     = KIND_GEN;
        radicand = SQ_RAD_W'(opposite ? disc_sum : disc_dif);
      end
    end else if (p_ext == q4) begin
      kind = KIND_DBL;
    end
  end

  assign wr_valid              = v2;
  assign wr_data.item.kind     = kind;
  assign wr_data.item.sa       = sa2;
  assign wr_data.item.sb       = sb2;
  assign wr_data.item.sc       = sc2;
  assign wr_data.item.ma       = ma2;
  assign wr_data.item.mb       = mb2;
  assign wr_data.item.mc       = mc2;
  assign wr_data.radicand      = radicand;

endmodule
`default_nettype wire

// ----- sv/qrs_fifo.sv -----
// Short queue between the front end and the solving back end.
`timescale 1ns / 1ps
`default_nettype none
module qrs_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire qrs_pkg::qitem_t in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output qrs_pkg::qitem_t      out_data
);
  import qrs_pkg::*;

  qitem_t                entry [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr, rptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  push, pop;

  assign in_ready  = count != FIFO_CNT_W'(FIFO_DEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = entry[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + FIFO_PTR_W'(1);
      if (pop)  rptr <= rptr + FIFO_PTR_W'(1);
      if (push && !pop)      count <= count + FIFO_CNT_W'(1);
      else if (pop && !push) count <= count - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wptr] <= in_data;
  end

endmodule
`default_nettype wire

// ----- sv/qrs_sqrt.sv -----
// Pipelined integer square root, two radicand bits per stage.
`timescale 1ns / 1ps
`default_nettype none
module qrs_sqrt (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic [qrs_pkg::SQ_RAD_W-1:0] radicand,
  input  wire qrs_pkg::item_t               in_side,
  output logic                              out_valid,
  output logic [qrs_pkg::SQ_ROOT_W-1:0]     root,
  output qrs_pkg::item_t                    out_side
);
  import qrs_pkg::*;

  localparam int STAGES = SQ_ROOT_W;

  logic                 v    [STAGES];
  logic [SQ_RAD_W-1:0]  rad  [STAGES];
  logic [SQ_REM_W-1:0]  rem  [STAGES];
  logic [SQ_ROOT_W-1:0] rt   [STAGES];
  item_t                side [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic                 v_i;
    logic [SQ_RAD_W-1:0]  rad_i;
    logic [SQ_REM_W-1:0]  rem_i;
    logic [SQ_ROOT_W-1:0] rt_i;
    item_t                side_i;
    logic [SQ_REM_W-1:0]  cur, trial;
    logic                 ge;

    if (g == 0) begin : g_first
      assign v_i    = in_valid;
      assign rad_i  = radicand;
      assign rem_i  = '0;
      assign rt_i   = '0;
      assign side_i = in_side;
    end else begin : g_rest
      assign v_i    = v[g-1];
      assign rad_i  = rad[g-1];
      assign rem_i  = rem[g-1];
      assign rt_i   = rt[g-1];
      assign side_i = side[g-1];
    end

    assign cur   = {rem_i[SQ_REM_W-3:0], rad_i[SQ_RAD_W-1 -: 2]};
    assign trial = {{(SQ_REM_W - SQ_ROOT_W - 2){1'b0}}, rt_i, 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) v[g] <= 1'b0;
      else if (en) v[g] <= v_i;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[g]  <= rad_i << 2;
        rem[g]  <= ge ? (cur - trial) : cur;
        rt[g]   <= {rt_i[SQ_ROOT_W-2:0], ge};
        side[g] <= side_i;
      end
    end
  end

  assign out_valid = v[STAGES-1];
  assign root      = rt[STAGES-1];
  assign out_side  = side[STAGES-1];

endmodule
`default_nettype wire

// ----- sv/qrs_div.sv -----
// Pipelined restoring divider with two lanes, one quotient bit per lane and stage.
`timescale 1ns / 1ps
`default_nettype none
module qrs_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [qrs_pkg::DIV_NUM_W-1:0] num_a,
  input  wire logic [qrs_pkg::DIV_DEN_W-1:0] den_a,
  input  wire logic [qrs_pkg::DIV_NUM_W-1:0] num_b,
  input  wire logic [qrs_pkg::DIV_DEN_W-1:0] den_b,
  input  wire qrs_pkg::item_t                in_side,
  output logic                               out_valid,
  output logic [qrs_pkg::DIV_NUM_W-1:0]      quo_a,
  output logic [qrs_pkg::DIV_NUM_W-1:0]      quo_b,
  output qrs_pkg::item_t                     out_side
);
  import qrs_pkg::*;

  localparam int STAGES = DIV_NUM_W;

  // The dividend register shifts left and collects the quotient bits at its bottom.
  logic                 v    [STAGES];
  logic [DIV_NUM_W-1:0] na   [STAGES];
  logic [DIV_DEN_W-1:0] ra   [STAGES];
  logic [DIV_DEN_W-1:0] da   [STAGES];
  logic [DIV_NUM_W-1:0] nb   [STAGES];
  logic [DIV_DEN_W-1:0] rb   [STAGES];
  logic [DIV_DEN_W-1:0] db   [STAGES];
  item_t                side [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic                 v_i;
    logic [DIV_NUM_W-1:0] na_i, nb_i;
    logic [DIV_DEN_W-1:0] ra_i, rb_i, da_i, db_i;
    item_t                side_i;
    logic [DIV_DEN_W:0]   cur_a, cur_b, dif_a, dif_b;
    logic                 ge_a, ge_b;

    if (g == 0) begin : g_first
      assign v_i    = in_valid;
      assign na_i   = num_a;
      assign nb_i   = num_b;
      assign ra_i   = '0;
      assign rb_i   = '0;
      assign da_i   = den_a;
      assign db_i   = den_b;
      assign side_i = in_side;
    end else begin : g_rest
      assign v_i    = v[g-1];
      assign na_i   = na[g-1];
      assign nb_i   = nb[g-1];
      assign ra_i   = ra[g-1];
      assign rb_i   = rb[g-1];
      assign da_i   = da[g-1];
      assign db_i   = db[g-1];
      assign side_i = side[g-1];
    end

    assign cur_a = {ra_i, na_i[DIV_NUM_W-1]};
    assign cur_b = {rb_i, nb_i[DIV_NUM_W-1]};
    assign dif_a = cur_a - {1'b0, da_i};
    assign dif_b = cur_b - {1'b0, db_i};
    assign ge_a  = cur_a >= {1'b0, da_i};
    assign ge_b  = cur_b >= {1'b0, db_i};

    always_ff @(posedge clk) begin
      if (rst) v[g] <= 1'b0;
      else if (en) v[g] <= v_i;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        na[g]   <= {na_i[DIV_NUM_W-2:0], ge_a};
        nb[g]   <= {nb_i[DIV_NUM_W-2:0], ge_b};
        ra[g]   <= ge_a ? dif_a[DIV_DEN_W-1:0] : cur_a[DIV_DEN_W-1:0];
        rb[g]   <= ge_b ? dif_b[DIV_DEN_W-1:0] : cur_b[DIV_DEN_W-1:0];
        da[g]   <= da_i;
        db[g]   <= db_i;
        side[g] <= side_i;
      end
    end
  end

  assign out_valid = v[STAGES-1];
  assign quo_a     = na[STAGES-1];
  assign quo_b     = nb[STAGES-1];
  assign out_side  = side[STAGES-1];

endmodule
`default_nettype wire

// ----- sv/qrs_back.sv -----
// Back end: square root, divisions, saturation, ordering and the output register.
`timescale 1ns / 1ps
`default_nettype none
module qrs_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            rd_valid,
  output logic                                 rd_ready,
  input  wire qrs_pkg::qitem_t                 rd_data,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [qrs_pkg::OUT_TDATA_W-1:0]      m_tdata
);
  import qrs_pkg::*;

  logic                 be;
  logic                 sq_valid;
  logic [SQ_ROOT_W-1:0] sq_root;
  item_t                sq_side;

  logic                 pr_valid;
  logic [DIV_NUM_W-1:0] pr_num_a, pr_num_b;
  logic [DIV_DEN_W-1:0] pr_den_a, pr_den_b;
  item_t                pr_side;
  logic [SUM_W-1:0]     m_sum;

  logic                 dv_valid;
  logic [DIV_NUM_W-1:0] quo_a, quo_b;
  item_t                dv_side;

  logic                 ps_valid;
  logic [COUNT_W-1:0]   ps_count;
  logic [COEF_W-1:0]    ps_ra, ps_rb;
  logic                 ps_ovf;
  logic [COEF_W:0]      qa_neg, qa_pos, qa_lin, qa_gen, qb_gen;

  logic                 out_valid;
  logic [COUNT_W-1:0]   out_count;
  logic [COEF_W-1:0]    out_lower, out_upper;
  logic                 out_ovf;
  logic                 swap;

  // Truncated magnitude with sign to a saturated root; the top bit flags saturation.
  function automatic logic [COEF_W:0] quant(input logic [DIV_NUM_W-1:0] mag, input logic neg);
    logic             o;
    logic [COEF_W-1:0] r;
    if (neg) begin
      o = mag > SAT_NEG_MAG;
      r = o ? ROOT_MIN : (~mag[COEF_W-1:0] + COEF_W'(1));
    end else begin
      o = mag > SAT_POS_MAG;
      r = o ? ROOT_MAX : mag[COEF_W-1:0];
    end
    return {o, r};
  endfunction

  assign be       = !out_valid || m_tready;
  assign rd_ready = be;

  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (be),
    .in_valid  (rd_valid),
    .radicand  (rd_data.radicand),
    .in_side   (rd_data.item),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  // m = |c1| + sqrt(disc) is twice the magnitude of the stable intermediate term.
  assign m_sum = {1'b0, sq_side.mb} + sq_root[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) pr_valid <= 1'b0;
    else if (be) pr_valid <= sq_valid;
  end

  always_ff @(posedge clk) begin
    if (be) begin
      pr_side  <= sq_side;
      pr_num_b <= '0;
      pr_den_b <= '0;
      case (sq_side.kind)
        KIND_GEN: begin
          pr_num_a <= {m_sum, {FRAC_BITS{1'b0}}};
          pr_den_a <= {sq_side.ma, 1'b0};
          pr_num_b <= {sq_side.mc, {(FRAC_BITS + 1){1'b0}}};
          pr_den_b <= m_sum;
        end
        KIND_LIN: begin
          pr_num_a <= {{(DIV_NUM_W - MAG_W - FRAC_BITS){1'b0}}, sq_side.mc, {FRAC_BITS{1'b0}}};
          pr_den_a <= {1'b0, sq_side.mb};
        end
        KIND_SYM: begin
          // floor(sqrt(c0/c2)) equals floor(isqrt(c0*c2) / c2), so the root comes first.
          pr_num_a <= {{(DIV_NUM_W - SQ_ROOT_W){1'b0}}, sq_root};
          pr_den_a <= {1'b0, sq_side.ma};
        end
        KIND_DBL: begin
          pr_num_a <= {{(DIV_NUM_W - MAG_W - FRAC_BITS){1'b0}}, sq_side.mb, {FRAC_BITS{1'b0}}};
          pr_den_a <= {sq_side.ma, 1'b0};
        end
        default: begin
          pr_num_a <= '0;
          pr_den_a <= '0;
        end
      endcase
    end
  end

  qrs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (be),
    .in_valid  (pr_valid),
    .num_a     (pr_num_a),
    .den_a     (pr_den_a),
    .num_b     (pr_num_b),
    .den_b     (pr_den_b),
    .in_side   (pr_side),
    .out_valid (dv_valid),
    .quo_a     (quo_a),
    .quo_b     (quo_b),
    .out_side  (dv_side)
  );

  assign qa_neg = quant(quo_a, 1'b1);
  assign qa_pos = quant(quo_a, 1'b0);
  assign qa_lin = quant(quo_a, !(dv_side.sc ^ dv_side.sb));
  assign qa_gen = quant(quo_a, !(dv_side.sb ^ dv_side.sa));
  assign qb_gen = quant(quo_b, !(dv_side.sc ^ dv_side.sb));

  always_ff @(posedge clk) begin
    if (rst) ps_valid <= 1'b0;
    else if (be) ps_valid <= dv_valid;
  end

  always_ff @(posedge clk) begin
    if (be) begin
      case (dv_side.kind)
        KIND_GEN: begin
          ps_count <= COUNT_TWO;
          ps_ra    <= qa_gen[COEF_W-1:0];
          ps_rb    <= qb_gen[COEF_W-1:0];
          ps_ovf   <= qa_gen[COEF_W] | qb_gen[COEF_W];
        end
        KIND_SYM: begin
          ps_count <= COUNT_TWO;
          ps_ra    <= qa_neg[COEF_W-1:0];
          ps_rb    <= qa_pos[COEF_W-1:0];
          ps_ovf   <= qa_neg[COEF_W] | qa_pos[COEF_W];
        end
        KIND_DBL: begin
          ps_count <= COUNT_TWO;
          ps_ra    <= qa_gen[COEF_W-1:0];
          ps_rb    <= qa_gen[COEF_W-1:0];
          ps_ovf   <= qa_gen[COEF_W];
        end
        KIND_LIN: begin
          ps_count <= COUNT_ONE;
          ps_ra    <= qa_lin[COEF_W-1:0];
          ps_rb    <= '0;
          ps_ovf   <= qa_lin[COEF_W];
        end
        default: begin
          ps_count <= COUNT_NONE;
          ps_ra    <= '0;
          ps_rb    <= '0;
          ps_ovf   <= 1'b0;
        end
      endcase
    end
  end

  assign swap = (ps_count == COUNT_TWO) && ($signed(ps_rb) < $signed(ps_ra));

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (be) out_valid <= ps_valid;
  end

  always_ff @(posedge clk) begin
    if (be) begin
      out_count <= ps_count;
      out_lower <= swap ? ps_rb : ps_ra;
      out_upper <= swap ? ps_ra : ps_rb;
      out_ovf   <= ps_ovf;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_TDATA_W - COUNT_W - 2 * COEF_W - 1){1'b0}},
                     out_ovf, out_upper, out_lower, out_count};

  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_count == COUNT_NONE) |-> (out_lower == '0) && (out_upper == '0) && !out_ovf)
    else $error("result without roots carries nonzero fields");

  a_pair_ordered: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_count == COUNT_TWO) |-> $signed(out_lower) <= $signed(out_upper))
    else $error("roots not in ascending order");

  a_single_upper_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_count == COUNT_ONE) |-> out_upper == '0)
    else $error("linear result carries an upper root");

  a_count_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_count == COUNT_NONE) || (out_count == COUNT_ONE) ||
                  (out_count == COUNT_TWO))
    else $error("illegal root count");

endmodule
`default_nettype wire

// ----- sv/quadratic_root_solver.sv -----
// Top level of the quadratic root solver: front end, queue and back end.
`timescale 1ns / 1ps
`default_nettype none
// Solves c2*t^2 + c1*t + c0 = 0 for signed Q16.16 coefficients and returns the number of real
// roots and the roots in ascending order, truncated toward zero and saturated, with an overflow
// flag. One transaction is taken per clock cycle and one result leaves per cycle while the
// output is not stalled; the back end holds the 48-stage square root pipeline and the
// 49-stage divider pipeline. A four-entry queue between the classifying front end and the
// back end absorbs short stalls on the output side.
module quadratic_root_solver (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // coef_const [31:0], coef_linear [63:32], coef_square [95:64]
  input  wire logic [qrs_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // root_count [1:0], root_lower [33:2], root_upper [65:34], overflow [66], zero [71:67]
  output logic [qrs_pkg::OUT_TDATA_W-1:0]      m_tdata
);
  import qrs_pkg::*;

  logic   wr_valid, wr_ready, rd_valid, rd_ready;
  qitem_t wr_data, rd_data;

  qrs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_data  (wr_data)
  );

  qrs_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (wr_valid),
    .in_ready  (wr_ready),
    .in_data   (wr_data),
    .out_valid (rd_valid),
    .out_ready (rd_ready),
    .out_data  (rd_data)
  );

  qrs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready),
    .rd_data  (rd_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire
